FILE: hdl/qhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhc_pkg
// Shared types and constants of the quaternion heading classifier: datapath
// widths, pipeline depths, CORDIC arctangent table and heading codes.
// ----------------------------------------------------------------------------
package qhc_pkg;

    // CORDIC micro-rotations per angle (8 to 30)
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 30;

    // Operand width of the atan2 units, internal vector width, angle accumulator
    localparam int OPW = 33;
    localparam int CW  = 36;
    localparam int ZW  = 26;
    localparam int AW  = ZW - 9;

    // atan(2^-i) in units of 2^-16 degree
    localparam logic [21:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
        22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
        22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
        22'd115,     22'd57,      22'd29,     22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,      22'd0
    };
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] ROUND_HALF   = ZW'(256);

    // Square root unit: radicand up to 2^60, one result bit per stage
    localparam int SQ_RAD_W  = 61;
    localparam int SQ_ROOT_W = 31;
    localparam int SQ_ACC_W  = 63;
    localparam int ISQ_STEPS = (SQ_RAD_W + 1) / 2;
    localparam int ISQ_LAT   = ISQ_STEPS + 1;

    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    // input, squares, radicand, sqrt, four product stages, sqrt, CORDIC, classify
    localparam int PIPE_DEPTH = 3 + ISQ_LAT + 4 + ISQ_LAT + CORDIC_LAT + 1;

    typedef enum logic [2:0] {
        HDG_DOWN     = 3'd0,
        HDG_UP       = 3'd1,
        HDG_RIGHT    = 3'd2,
        HDG_LEFT     = 3'd3,
        HDG_BACKWARD = 3'd4,
        HDG_FORWARD  = 3'd5,
        HDG_NONE     = 3'd6
    } t_heading;

    typedef enum logic [1:0] {
        CFG_PITCH_LIMIT = 2'd0,
        CFG_YAW_INNER   = 2'd1,
        CFG_YAW_OUTER   = 2'd2
    } t_cfg_index;

    localparam logic [6:0] PITCH_LIMIT_RST = 7'd50;
    localparam logic [7:0] YAW_INNER_RST   = 8'd45;
    localparam logic [7:0] YAW_OUTER_RST   = 8'd135;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        t_heading           code;
    } t_result;

endpackage

FILE: hdl/qhc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhc_isqrt
// Pipelined integer square root, floor(sqrt(radicand)), one root bit per stage.
// ----------------------------------------------------------------------------
module qhc_isqrt import qhc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  logic [SQ_RAD_W-1:0]  i_rad,
    output logic [SQ_ROOT_W-1:0] o_root
);

    logic [SQ_RAD_W-1:0] r_n [0:ISQ_STEPS];
    logic [SQ_ACC_W-1:0] r_r [0:ISQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_n[0] <= i_rad;
            r_r[0] <= '0;
        end
    end

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
        localparam logic [SQ_ACC_W-1:0] BIT = SQ_ACC_W'(1) << (SQ_RAD_W - 1 - 2 * k);
        logic [SQ_ACC_W-1:0] trial;
        logic [SQ_ACC_W-1:0] n_ext;
        assign trial = r_r[k] + BIT;
        assign n_ext = SQ_ACC_W'(r_n[k]);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (n_ext >= trial) begin
                    r_n[k+1] <= SQ_RAD_W'(n_ext - trial);
                    r_r[k+1] <= (r_r[k] >> 1) + BIT;
                end else begin
                    r_n[k+1] <= r_n[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
            end
        end
    end

    assign o_root = r_r[ISQ_STEPS][SQ_ROOT_W-1:0];

endmodule

FILE: hdl/qhc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhc_cordic
// Pipelined CORDIC vectoring atan2, result rounded to 1/128 degree.
// ----------------------------------------------------------------------------
module qhc_cordic import qhc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_ce,
    input  logic signed [OPW-1:0] i_y,
    input  logic signed [OPW-1:0] i_x,
    output logic signed [AW-1:0]  o_angle
);

    logic signed [CW-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z    [0:CORDIC_STEPS];
    logic                 r_zero [0:CORDIC_STEPS];
    logic signed [AW-1:0] r_angle;

    logic signed [CW-1:0] xe, ye, n_x, n_y;
    logic signed [ZW-1:0] n_z, z_rnd;

    assign xe = $signed({{(CW-OPW){i_x[OPW-1]}}, i_x});
    assign ye = $signed({{(CW-OPW){i_y[OPW-1]}}, i_y});

    // Turn a left-half-plane vector by a quarter turn toward the x axis
    always_comb begin
        n_x = xe;
        n_y = ye;
        n_z = '0;
        if (xe < 0) begin
            if (ye >= 0) begin
                n_x = ye;
                n_y = -xe;
                n_z = QUARTER_TURN;
            end else begin
                n_x = -ye;
                n_y = xe;
                n_z = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [ZW-1:0] ANG = $signed({{(ZW-22){1'b0}}, ATAN_TAB[k]});
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_zero[k+1] <= r_zero[k];
                if (r_y[k] < 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ANG;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ANG;
                end
            end
        end
    end

    assign z_rnd = r_z[CORDIC_STEPS] + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_angle <= r_zero[CORDIC_STEPS] ? '0 : AW'(z_rnd >>> 9);
        end
    end

    assign o_angle = r_angle;

endmodule

FILE: hdl/quaternion_heading_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_heading_classifier_top
// Orientation sample to roll, pitch, yaw and a heading code.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless stalled: the three Q30 vector parts of a
// unit quaternion in tdata and a sample-valid flag in tuser. The scalar part
// is rebuilt as sqrt(1 - |v|^2) (zero when |v|^2 >= 1), then roll, pitch and
// yaw come out in 1/128 degree together with a heading code (down, up, right,
// left, backward, forward, none). Beats whose flag is low are consumed and
// give no result. Throughput is one beat per cycle while not stalled; the
// path from acceptance to the output buffer runs through the two 32-stage
// square-root pipelines in series with the 18-stage CORDIC units (16 CORDIC steps).
// The pipeline stalls as a whole only when its last stage holds a result and
// the two-entry output buffer is full, so input beats keep flowing while a
// result waits. The three limit registers are written through the config
// channel, which is always ready; write them only while the block is idle.
// ----------------------------------------------------------------------------
module quaternion_heading_classifier_top import qhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // quat_x[31:0], quat_y[63:32], quat_z[95:64]
    input  logic [0:0]  i_s_axis_tuser,   // sample_valid[0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
    output logic [2:0]  o_m_axis_tuser,   // heading_code[2:0]
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    typedef struct packed {
        logic signed [31:0]    x;
        logic signed [31:0]    y;
        logic signed [31:0]    z;
        logic signed [63:0]    yz;
        logic signed [63:0]    xy;
        logic signed [63:0]    zx;
        logic signed [OPW-1:0] roll_x;
        logic signed [OPW-1:0] yaw_x;
    } t_pay1;

    typedef struct packed {
        logic signed [OPW-1:0] roll_y;
        logic signed [OPW-1:0] roll_x;
        logic signed [OPW-1:0] yaw_y;
        logic signed [OPW-1:0] yaw_x;
        logic signed [31:0]    t;
    } t_pay2;

    localparam logic [63:0]         ONE_Q60  = 64'd1 << 60;
    localparam logic signed [64:0]  HALF_Q60 = 65'sd1 <<< 59;
    localparam logic signed [34:0]  S_HI     = 35'sd1 <<< 29;
    localparam logic signed [31:0]  T_MAX    = 32'sd1 <<< 30;

    // ---------------- config registers ----------------
    logic [6:0] r_pitch_limit;
    logic [7:0] r_yaw_inner;
    logic [7:0] r_yaw_outer;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_limit <= PITCH_LIMIT_RST;
            r_yaw_inner   <= YAW_INNER_RST;
            r_yaw_outer   <= YAW_OUTER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PITCH_LIMIT: r_pitch_limit <= i_cfg_data[6:0];
                CFG_YAW_INNER:   r_yaw_inner   <= i_cfg_data;
                CFG_YAW_OUTER:   r_yaw_outer   <= i_cfg_data;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------- stall control ----------------
    // Advance the whole pipeline unless a finished result has nowhere to go.
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [1:0]            r_cnt;
    logic                  ce;

    assign ce              = !r_vld[PIPE_DEPTH-1] || (r_cnt != 2'd2);
    assign o_s_axis_tready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            // only beats flagged as samples carry a result down the pipe
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid & i_s_axis_tuser[0]};
        end
    end

    // ---------------- S0: capture ----------------
    logic signed [31:0] r_x0, r_y0, r_z0;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x0 <= i_s_axis_tdata[31:0];
            r_y0 <= i_s_axis_tdata[63:32];
            r_z0 <= i_s_axis_tdata[95:64];
        end
    end

    // ---------------- S1: squares and cross products ----------------
    logic [31:0]        ax, ay, az;
    logic [63:0]        r_sqx, r_sqy, r_sqz;
    logic signed [63:0] r_yz, r_xy, r_zx;
    logic signed [31:0] r_x1, r_y1, r_z1;

    assign ax = r_x0[31] ? 32'(-r_x0) : r_x0;
    assign ay = r_y0[31] ? 32'(-r_y0) : r_y0;
    assign az = r_z0[31] ? 32'(-r_z0) : r_z0;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sqx <= 64'(ax) * 64'(ax);
            r_sqy <= 64'(ay) * 64'(ay);
            r_sqz <= 64'(az) * 64'(az);
            r_yz  <= r_y0 * r_z0;
            r_xy  <= r_x0 * r_y0;
            r_zx  <= r_z0 * r_x0;
            r_x1  <= r_x0;
            r_y1  <= r_y0;
            r_z1  <= r_z0;
        end
    end

    // ---------------- S2: radicand and atan2 denominators ----------------
    logic [63:0]         sum3, sum_xy, sum_yz;
    logic signed [64:0]  hm_roll, hm_yaw;
    logic [SQ_RAD_W-1:0] r_s2_rad;
    t_pay1               r_s2_pay;

    assign sum_xy  = r_sqx + r_sqy;
    assign sum_yz  = r_sqy + r_sqz;
    assign sum3    = sum_xy + r_sqz;
    assign hm_roll = HALF_Q60 - $signed({1'b0, sum_xy});
    assign hm_yaw  = HALF_Q60 - $signed({1'b0, sum_yz});

    always_ff @(posedge i_clk) begin
        if (ce) begin
            // a vector part of norm one or more leaves no scalar part
            r_s2_rad        <= (sum3 >= ONE_Q60) ? '0 : SQ_RAD_W'(ONE_Q60 - sum3);
            r_s2_pay.x      <= r_x1;
            r_s2_pay.y      <= r_y1;
            r_s2_pay.z      <= r_z1;
            r_s2_pay.yz     <= r_yz;
            r_s2_pay.xy     <= r_xy;
            r_s2_pay.zx     <= r_zx;
            r_s2_pay.roll_x <= hm_roll[64:32];
            r_s2_pay.yaw_x  <= hm_yaw[64:32];
        end
    end

    // ---------------- scalar part w ----------------
    logic [SQ_ROOT_W-1:0] w_root;
    t_pay1                r_dl1 [0:ISQ_LAT-1];

    qhc_isqrt u_isqrt_w (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_rad  (r_s2_rad),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dl1[0] <= r_s2_pay;
            for (int k = 1; k < ISQ_LAT; k++) begin
                r_dl1[k] <= r_dl1[k-1];
            end
        end
    end

    // ---------------- Sa: products with w ----------------
    logic signed [31:0] ws;
    logic signed [63:0] r_wx, r_wy, r_wz, r_sa_yz, r_sa_xy, r_sa_zx;
    logic signed [OPW-1:0] r_sa_roll_x, r_sa_yaw_x;
    t_pay1              pa;

    assign pa = r_dl1[ISQ_LAT-1];
    assign ws = $signed({1'b0, w_root});

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_wx        <= ws * pa.x;
            r_wy        <= ws * pa.y;
            r_wz        <= ws * pa.z;
            r_sa_yz     <= pa.yz;
            r_sa_xy     <= pa.xy;
            r_sa_zx     <= pa.zx;
            r_sa_roll_x <= pa.roll_x;
            r_sa_yaw_x  <= pa.yaw_x;
        end
    end

    // ---------------- Sb: numerators and clamped pitch sine ----------------
    logic signed [64:0] num_roll, num_yaw, num_pitch;
    logic signed [34:0] s_val;
    logic signed [31:0] t_val;
    t_pay2              r_sb_pay;

    assign num_roll  = 65'(r_wx) + 65'(r_sa_yz);
    assign num_yaw   = 65'(r_wz) + 65'(r_sa_xy);
    assign num_pitch = 65'(r_wy) - 65'(r_sa_zx);
    assign s_val     = num_pitch[64:30];

    always_comb begin
        if (s_val > S_HI) begin
            t_val = T_MAX;
        end else if (s_val < -S_HI) begin
            t_val = -T_MAX;
        end else begin
            t_val = 32'(s_val <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sb_pay.roll_y <= num_roll[64:32];
            r_sb_pay.roll_x <= r_sa_roll_x;
            r_sb_pay.yaw_y  <= num_yaw[64:32];
            r_sb_pay.yaw_x  <= r_sa_yaw_x;
            r_sb_pay.t      <= t_val;
        end
    end

    // ---------------- Sc: t squared ----------------
    logic [30:0] at;
    logic [61:0] r_sc_tsq;
    t_pay2       r_sc_pay;

    assign at = r_sb_pay.t[31] ? 31'(-r_sb_pay.t) : 31'(r_sb_pay.t);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sc_tsq <= at * at;
            r_sc_pay <= r_sb_pay;
        end
    end

    // ---------------- Sd: pitch cosine radicand ----------------
    logic [SQ_RAD_W-1:0] r_sd_rad;
    t_pay2               r_sd_pay;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sd_rad <= SQ_RAD_W'(ONE_Q60 - 64'(r_sc_tsq));
            r_sd_pay <= r_sc_pay;
        end
    end

    // ---------------- pitch cosine ----------------
    logic [SQ_ROOT_W-1:0] c_root;
    t_pay2                r_dl2 [0:ISQ_LAT-1];
    t_pay2                pc;

    qhc_isqrt u_isqrt_c (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_rad  (r_sd_rad),
        .o_root (c_root)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dl2[0] <= r_sd_pay;
            for (int k = 1; k < ISQ_LAT; k++) begin
                r_dl2[k] <= r_dl2[k-1];
            end
        end
    end

    assign pc = r_dl2[ISQ_LAT-1];

    // ---------------- three atan2 units in parallel ----------------
    logic signed [AW-1:0]  roll_a, pitch_a, yaw_a;
    logic signed [OPW-1:0] pitch_y, pitch_x;

    assign pitch_y = $signed({{(OPW-32){pc.t[31]}}, pc.t});
    assign pitch_x = $signed({{(OPW-SQ_ROOT_W){1'b0}}, c_root});

    qhc_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_y     (pc.roll_y),
        .i_x     (pc.roll_x),
        .o_angle (roll_a)
    );

    qhc_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_y     (pitch_y),
        .i_x     (pitch_x),
        .o_angle (pitch_a)
    );

    qhc_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_y     (pc.yaw_y),
        .i_x     (pc.yaw_x),
        .o_angle (yaw_a)
    );

    // ---------------- classify ----------------
    // Limits are whole degrees; angles are 1/128 degree.
    logic signed [17:0] pl, il, ol, pa18, ya18;
    t_heading           n_code;
    t_result            r_res;

    assign pl   = $signed({4'd0, r_pitch_limit, 7'd0});
    assign il   = $signed({3'd0, r_yaw_inner, 7'd0});
    assign ol   = $signed({3'd0, r_yaw_outer, 7'd0});
    assign pa18 = 18'(pitch_a);
    assign ya18 = 18'(yaw_a);

    always_comb begin
        if (pa18 < -pl) begin
            n_code = HDG_DOWN;
        end else if (pa18 > pl) begin
            n_code = HDG_UP;
        end else if (ya18 < -il && ya18 > -ol) begin
            n_code = HDG_RIGHT;
        end else if (ya18 > il && ya18 < ol) begin
            n_code = HDG_LEFT;
        end else if (ya18 > ol || ya18 < -ol) begin
            n_code = HDG_BACKWARD;
        end else if (ya18 < il && ya18 > -il) begin
            n_code = HDG_FORWARD;
        end else begin
            n_code = HDG_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_res.roll  <= roll_a[15:0];
            r_res.pitch <= pitch_a[14:0];
            r_res.yaw   <= yaw_a[15:0];
            r_res.code  <= n_code;
        end
    end

    // ---------------- output buffer, two entries ----------------
    t_result r_ob [0:1];
    logic    r_wr, r_rd;
    logic    push, pop;

    assign push = ce && r_vld[PIPE_DEPTH-1];
    assign pop  = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ob[r_wr] <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {1'b0, r_ob[r_rd].yaw, r_ob[r_rd].pitch, r_ob[r_rd].roll};
    assign o_m_axis_tuser  = r_ob[r_rd].code;

    // ---------------- assertions ----------------
    // a finished result never meets a full buffer while the pipe advances
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_DEPTH-1] && r_cnt == 2'd2) |-> !o_s_axis_tready)
        else $error("result pushed into full output buffer");

    // a stall freezes every valid bit in place
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |=> r_vld == $past(r_vld))
        else $error("pipeline moved during stall");

    // the buffer never reports a count beyond its two entries
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    // a delivered heading is always a defined code
    a_code_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= HDG_NONE)
        else $error("undefined heading code on output");

endmodule

FILE: tb/tb_quaternion_heading_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_heading_classifier_top
// Self-checking bench for the quaternion heading classifier.
// ----------------------------------------------------------------------------
// Streams orientation samples into the block and predicts each result with an
// exact wide-integer model of the square roots, CORDIC atan2 and heading rules.
// A short directed list hits the extremes, then random samples follow, mostly
// inside the unit ball, across several limit settings. Both stream sides idle
// at random; one long output hold-off fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
import qhc_pkg::*;

typedef logic signed [127:0] wide_t;

class heading_scoreboard;
    t_result     pending[$];
    int unsigned pitch_lim = PITCH_LIMIT_RST;
    int unsigned inner_lim = YAW_INNER_RST;
    int unsigned outer_lim = YAW_OUTER_RST;

    function void write_reg(logic [1:0] idx, logic [7:0] data);
        case (idx)
            CFG_PITCH_LIMIT: pitch_lim = data[6:0];
            CFG_YAW_INNER:   inner_lim = data;
            CFG_YAW_OUTER:   outer_lim = data;
            default: ;
        endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring CORDIC, result rounded to 1/128 degree
    function longint angle_of(wide_t y, wide_t x);
        wide_t  nx;
        wide_t  dx;
        wide_t  dy;
        longint z;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; y = -x; x = nx; z = longint'(QUARTER_TURN);
            end else begin
                nx = -y; y = x; x = nx; z = -longint'(QUARTER_TURN);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
        end
        return (z + 256) >>> 9;
    endfunction

    function void note(logic valid, logic [95:0] data);
        wide_t    x, y, z, w, sum, s, t, one, half;
        longint   roll, pitch, yaw, p, lo, hi;
        t_heading code;
        t_result  r;
        if (!valid) return;
        one  = wide_t'(64'sh1000_0000_0000_0000);
        half = one >>> 1;
        x = wide_t'($signed(data[31:0]));
        y = wide_t'($signed(data[63:32]));
        z = wide_t'($signed(data[95:64]));
        sum = x * x + y * y + z * z;
        w = (sum >= one) ? wide_t'(0) : wide_t'({64'b0, int_sqrt(64'(one - sum))});
        roll = angle_of((w * x + y * z) >>> 32, (half - (x * x + y * y)) >>> 32);
        s = (w * y - z * x) >>> 30;
        t = 2 * s;
        if (t > (one >>> 30)) t = one >>> 30;
        if (t < -(one >>> 30)) t = -(one >>> 30);
        pitch = angle_of(t, wide_t'({64'b0, int_sqrt(64'(one - t * t))}));
        yaw = angle_of((w * z + x * y) >>> 32, (half - (y * y + z * z)) >>> 32);
        p  = pitch_lim * 128;
        lo = inner_lim * 128;
        hi = outer_lim * 128;
        if (pitch < -p)                  code = HDG_DOWN;
        else if (pitch > p)              code = HDG_UP;
        else if (yaw < -lo && yaw > -hi) code = HDG_RIGHT;
        else if (yaw > lo && yaw < hi)   code = HDG_LEFT;
        else if (yaw > hi || yaw < -hi)  code = HDG_BACKWARD;
        else if (yaw < lo && yaw > -lo)  code = HDG_FORWARD;
        else                             code = HDG_NONE;
        r.roll  = roll[15:0];
        r.pitch = pitch[14:0];
        r.yaw   = yaw[15:0];
        r.code  = code;
        pending.push_back(r);
    endfunction

    function int check(logic [47:0] data, logic [2:0] user);
        t_result e;
        int      bad;
        bad = 0;
        if (pending.size() == 0) begin
            $display("%0t: result with none expected: data %h code %0d", $time, data, user);
            return 1;
        end
        e = pending.pop_front();
        if (data[15:0] !== e.roll) begin
            $display("%0t: roll exp %0d got %0d", $time, e.roll, $signed(data[15:0]));
            bad++;
        end
        if (data[30:16] !== e.pitch) begin
            $display("%0t: pitch exp %0d got %0d", $time, e.pitch, $signed(data[30:16]));
            bad++;
        end
        if (data[46:31] !== e.yaw) begin
            $display("%0t: yaw exp %0d got %0d", $time, e.yaw, $signed(data[46:31]));
            bad++;
        end
        if (user !== e.code) begin
            $display("%0t: code exp %0d got %0d", $time, e.code, user);
            bad++;
        end
        return bad;
    endfunction
endclass

module tb_quaternion_heading_classifier_top;

    localparam logic [1:0] CFG_NO_REG = 2'd3;   // unmapped index, must be ignored
    localparam int         Q_ONE      = 1 << 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    heading_scoreboard sb = new();
    int  errors = 0;
    bit  hold_req = 0;     // ask the sink for one long hold-off
    bit  sink_run = 0;

    quaternion_heading_classifier_top DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sample both streams at the edge; values read here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note(i_s_axis_tuser[0], i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready)
                errors += sb.check(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sink: random back-pressure, plus one long hold counted here.
    initial begin
        int hold_cnt;
        int idle;
        hold_cnt = 0;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = 400;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_axis_tready <= 1'b0;
            end else if (!sink_run) begin
                i_m_axis_tready <= 1'b1;
            end else if (idle > 0) begin
                idle--;
                i_m_axis_tready <= 1'b0;
            end else begin
                idle = gap_len();
                i_m_axis_tready <= (idle == 0);
            end
        end
    end

    task automatic send_beat(logic valid, logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
                             bit gaps);
        int g;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= valid;
        i_s_axis_tdata  <= {qz, qy, qx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Hold the input off until everything is back, then let stray work drain.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_part(int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic random_burst(int n);
        int          kind;
        logic [31:0] a, b, c;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                // well inside the unit ball: real scalar part
                a = rand_part(Q_ONE / 2); b = rand_part(Q_ONE / 2); c = rand_part(Q_ONE / 2);
            end else if (kind < 80) begin
                a = rand_part(Q_ONE); b = rand_part(Q_ONE); c = rand_part(Q_ONE);
            end else if (kind < 90) begin
                a = $urandom; b = $urandom; c = $urandom;
            end else begin
                // near one axis
                a = rand_part(Q_ONE / 64); b = rand_part(Q_ONE / 64); c = rand_part(Q_ONE / 64);
                case ($urandom_range(2))
                    0: a = rand_part(Q_ONE);
                    1: b = rand_part(Q_ONE);
                    default: c = rand_part(Q_ONE);
                endcase
            end
            send_beat($urandom_range(99) < 88, a, b, c, 1'b1);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, unit axes, extremes, norm over one, invalid.
        send_beat(1'b1, 32'd0, 32'd0, 32'd0, 1'b0);
        send_beat(1'b1, Q_ONE, 32'd0, 32'd0, 1'b0);
        send_beat(1'b1, -Q_ONE, 32'd0, 32'd0, 1'b0);
        send_beat(1'b1, 32'd0, Q_ONE, 32'd0, 1'b0);
        send_beat(1'b1, 32'd0, -Q_ONE, 32'd0, 1'b0);
        send_beat(1'b1, 32'd0, 32'd0, Q_ONE, 1'b0);
        send_beat(1'b1, 32'd0, 32'd0, -Q_ONE, 1'b0);
        send_beat(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_beat(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_beat(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_beat(1'b1, Q_ONE, Q_ONE, Q_ONE, 1'b0);
        send_beat(1'b1, 32'd0, 32'd488_000_000, 32'd0, 1'b0);     // pitch up
        send_beat(1'b1, 32'd0, -32'd488_000_000, 32'd0, 1'b0);    // pitch down
        send_beat(1'b1, 32'd0, 32'd0, 32'd700_000_000, 1'b0);     // left
        send_beat(1'b1, 32'd0, 32'd0, -32'd700_000_000, 1'b0);    // right
        send_beat(1'b1, 32'd0, 32'd0, 32'd1_050_000_000, 1'b0);   // backward
        send_beat(1'b1, 32'd0, 32'd0, 32'd410_903_000, 1'b0);     // near the boundary
        send_beat(1'b1, 32'd759_250_125, 32'd0, 32'd0, 1'b0);     // roll 90
        send_beat(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_beat(1'b0, 32'd0, 32'd0, 32'd0, 1'b0);
        drain();

        // Default limits, random traffic with the long output hold in the middle.
        sink_run = 1;
        random_burst(100);
        hold_req = 1;
        random_burst(150);
        drain();

        // Widest pitch, no forward sector, outer limit at 180 degrees.
        write_cfg(CFG_PITCH_LIMIT, 8'd90);
        write_cfg(CFG_YAW_INNER, 8'd0);
        write_cfg(CFG_YAW_OUTER, 8'd180);
        random_burst(180);
        drain();

        // Zero pitch limit, inner above outer; unmapped index must change nothing.
        write_cfg(CFG_PITCH_LIMIT, 8'd0);
        write_cfg(CFG_YAW_INNER, 8'd180);
        write_cfg(CFG_YAW_OUTER, 8'd0);
        write_cfg(CFG_NO_REG, 8'hFF);
        random_burst(180);
        drain();

        // Out-of-range values, stored bits only.
        write_cfg(CFG_PITCH_LIMIT, 8'hFF);
        write_cfg(CFG_YAW_INNER, 8'hFF);
        write_cfg(CFG_YAW_OUTER, 8'hAA);
        random_burst(120);
        drain();

        // Random settings.
        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(CFG_PITCH_LIMIT, 8'($urandom_range(90)));
            write_cfg(CFG_YAW_INNER, 8'($urandom_range(90)));
            write_cfg(CFG_YAW_OUTER, 8'($urandom_range(90, 180)));
            random_burst(80);
            drain();
        end

        if (sb.pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
            errors++;
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
